### src/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and types for the LRU key/value cache: field widths,
// request and result structures, and the get/put action codes.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // Default geometry, used as the defaults of the top level's parameters.
   localparam int MAX_ENTRIES_DEF = 16;
   localparam int KEY_WIDTH_DEF   = 32;

   // Fixed field widths of the item ports.
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 31;
   localparam int READ_W  = 32;
   localparam int CFG_W   = 5;

   localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

   // Value returned on a lookup miss.
   localparam logic signed [READ_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      ACTION_GET = 1'b0,
      ACTION_PUT = 1'b1
   } action_type;

   typedef struct packed {
      action_type                action;
      logic signed [KEY_W-1:0]   key;
      logic        [VALUE_W-1:0] value;
   } lkvc_req_type;

   typedef struct packed {
      logic                     valid;
      logic                     found;
      logic signed [READ_W-1:0] read_value;
   } lkvc_res_type;

endpackage

### src/lkvc_engine.sv
// ----------------------------------------------------------------------------
// lkvc_engine
// Entry store and sequencer of the LRU cache: sweeps the entry memory to
// find a key, then, on a hit or a put, sweeps it again to age ranks, evict and insert.
// ----------------------------------------------------------------------------
module lkvc_engine #(
   parameter int  MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
   parameter int  KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  lkvc_pkg::lkvc_req_type req,
   input  logic [CNT_W-1:0]      cap_eff,
   output lkvc_pkg::lkvc_res_type res,
   input  logic                  res_ready,
   output logic                  busy
);
   import lkvc_pkg::*;

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SKEY_W = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
   localparam int WORD_W = SKEY_W + VALUE_W + IDX_W;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_ENTRIES);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_DECIDE = 6'b000100,
      S_UPDATE = 6'b001000,
      S_INSERT = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   // Each word holds {key, value, rank}.
   logic [WORD_W-1:0] entry_mem [MAX_ENTRIES];

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   q_live_ff;
   logic [IDX_W-1:0]       q_idx_ff;
   logic [WORD_W-1:0]      q_word_ff;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       occ_ff, occ_in;
   lkvc_req_type           req_ff, req_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]       hit_rank_ff, hit_rank_in;
   logic [VALUE_W-1:0]     hit_value_ff, hit_value_in;
   logic                   evict_ff, evict_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   found_ff, found_in;

   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [WORD_W-1:0]      wr_data;

   logic [SKEY_W-1:0]      q_key;
   logic [VALUE_W-1:0]     q_value;
   logic [IDX_W-1:0]       q_rank;
   logic                   q_valid;
   logic [SKEY_W-1:0]      req_key_s;
   logic                   match;
   logic                   evict_now;
   logic [CNT_W-1:0]       cap_last;

   assign q_key     = q_word_ff[WORD_W-1 -: SKEY_W];
   assign q_value   = q_word_ff[IDX_W+VALUE_W-1 -: VALUE_W];
   assign q_rank    = q_word_ff[IDX_W-1:0];
   assign q_valid   = valid_ff[q_idx_ff];
   assign req_key_s = req_ff.key[SKEY_W-1:0];
   assign match     = q_live_ff && q_valid && (q_key == req_key_s);
   assign cap_last  = cap_eff - CNT_W'(1);
   assign evict_now = evict_ff && (CNT_W'(q_rank) >= cap_last);
   assign busy      = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      req_in        = req_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rank_in   = hit_rank_ff;
      hit_value_in  = hit_value_ff;
      evict_in      = evict_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      found_in      = found_ff;
      rd_en         = 1'b0;
      rd_addr       = cnt_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = q_idx_ff;
      wr_data       = q_word_ff;
      res           = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               cnt_in   = '0;
               hit_in   = 1'b0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (cnt_ff != LAST_CNT) begin
               rd_en  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (match && !hit_ff) begin
               hit_in       = 1'b1;
               hit_idx_in   = q_idx_ff;
               hit_rank_in  = q_rank;
               hit_value_in = q_value;
            end
            if (cnt_ff == LAST_CNT) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cnt_in        = '0;
            free_found_in = 1'b0;
            evict_in      = (occ_ff >= cap_eff);
            if (hit_ff) begin
               state_in = S_UPDATE;
            end else if (req_ff.action == ACTION_GET) begin
               found_in = 1'b0;
               state_in = S_RESP;
            end else begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (cnt_ff != LAST_CNT) begin
               rd_en  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (q_live_ff && q_valid) begin
               wr_en = 1'b1;
               if (hit_ff) begin
                  if (q_idx_ff == hit_idx_ff) begin
                     wr_data[IDX_W-1:0] = '0;
                     if (req_ff.action == ACTION_PUT) begin
                        wr_data[IDX_W+VALUE_W-1 -: VALUE_W] = req_ff.value;
                     end
                  end else if (q_rank < hit_rank_ff) begin
                     wr_data[IDX_W-1:0] = q_rank + IDX_W'(1);
                  end
               end else if (evict_now) begin
                  wr_en              = 1'b0;
                  valid_in[q_idx_ff] = 1'b0;
                  occ_in             = occ_ff - CNT_W'(1);
               end else begin
                  wr_data[IDX_W-1:0] = q_rank + IDX_W'(1);
               end
            end
            // The first entry that is empty, or emptied now, takes the new key.
            if (q_live_ff && !free_found_ff && (!q_valid || (!hit_ff && evict_now))) begin
               free_found_in = 1'b1;
               free_idx_in   = q_idx_ff;
            end
            if (cnt_ff == LAST_CNT) begin
               if (!hit_ff) begin
                  state_in = S_INSERT;
               end else if (req_ff.action == ACTION_GET) begin
                  found_in = 1'b1;
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_INSERT: begin
            if (free_found_ff) begin
               wr_en                 = 1'b1;
               wr_addr               = free_idx_ff;
               wr_data               = {req_key_s, req_ff.value, IDX_W'(0)};
               valid_in[free_idx_ff] = 1'b1;
               occ_in                = occ_ff + CNT_W'(1);
            end
            state_in = S_IDLE;
         end
         S_RESP: begin
            res.valid      = 1'b1;
            res.found      = found_ff;
            res.read_value = found_ff ? READ_W'({1'b0, hit_value_ff}) : MISS_VALUE;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_word_ff <= entry_mem[rd_addr];
         q_idx_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         q_live_ff     <= 1'b0;
         valid_ff      <= '0;
         occ_ff        <= '0;
         hit_ff        <= 1'b0;
         evict_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         q_live_ff     <= rd_en;
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
         hit_ff        <= hit_in;
         evict_ff      <= evict_in;
         free_found_ff <= free_found_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      hit_value_ff <= hit_value_in;
      free_idx_ff  <= free_idx_in;
   end

endmodule

### src/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request item is a get or a put. A get returns one response item: found
// and the stored value on a hit (the entry becomes most recent), or found low
// and a value of all ones on a miss. A put updates a present key, or inserts a
// new key as most recent, evicting the least recent entries when the cache
// already holds capacity_in_use entries; a put returns nothing. One item is
// worked on at a time. All entries live in a single memory with a registered
// read, and the item's cost is set by sweeps over that memory: one search
// sweep, then, for a hit or a new key, an update sweep that ages ranks,
// evicts and finds a free slot. The response sits in an output register, so
// a new request is taken while a response waits. The cache is empty after
// reset and needs no clearing pass. capacity_in_use may only be written
// while no item is in flight; 0 acts as 1 and values above MAX_ENTRIES act
// as MAX_ENTRIES. Lowering it evicts only on the next put of a new key.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic signed [lkvc_pkg::KEY_W-1:0]    req_lookup_key,
   input  logic        [lkvc_pkg::VALUE_W-1:0]  req_store_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic signed [lkvc_pkg::READ_W-1:0]   rsp_read_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [lkvc_pkg::CFG_W-1:0]    csr_capacity_in_use
);
   import lkvc_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   logic [CFG_W-1:0]          capacity_ff, capacity_in;
   logic [CMP_W-1:0]          cap_wide;
   logic [CNT_W-1:0]          cap_eff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff;
   logic signed [READ_W-1:0]  rsp_value_ff;

   lkvc_req_type              req_pkt;
   lkvc_res_type              res;
   logic                      start;
   logic                      busy;
   logic                      out_free;
   logic                      load;

   // The configuration register is always ready to take a write.
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_capacity_in_use : capacity_ff;

   // Clamp the programmed capacity into the range the store supports.
   always_comb begin
      cap_wide = CMP_W'(capacity_ff);
      if (cap_wide == '0) begin
         cap_wide = CMP_W'(1);
      end else if (cap_wide > CMP_W'(MAX_ENTRIES)) begin
         cap_wide = CMP_W'(MAX_ENTRIES);
      end
      cap_eff = cap_wide[CNT_W-1:0];
   end

   // A new request item is taken whenever the engine is idle.
   assign req_ready      = !busy;
   assign start          = req_valid && req_ready;
   assign req_pkt.action = action_type'(req_action);
   assign req_pkt.key    = req_lookup_key;
   assign req_pkt.value  = req_store_value;

   lkvc_engine #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_pkt),
      .cap_eff   (cap_eff),
      .res       (res),
      .res_ready (out_free),
      .busy      (busy)
   );

   // Output register: the engine hands over its result when the slot is free.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign load         = res.valid && out_free;
   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_found_ff <= res.found;
         rsp_value_ff <= res.read_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

   // An accepted item always starts the engine.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("engine did not start on an accepted item");

   // A result the output register cannot take stays put in the engine.
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (res.valid && !out_free) |=> (res.valid && $stable(res.read_value)
                                    && $stable(res.found)))
      else $error("pending result changed or vanished");

   // A result handed over shows up on the response port.
   a_res_load: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded result not presented");

   // No request is taken while the engine still holds a result.
   a_res_blocks: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> !req_ready)
      else $error("request taken while a result is pending");

endmodule

### sim/lru_key_value_cache_unit_test.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_test
// Self-checking testbench for the LRU key/value cache. A behavioral copy of
// the cache predicts every get result; each result item from the block is
// compared field by field against the oldest prediction. Directed tests
// cover key and value extremes, updates, shrinking capacity and the capacity
// corner settings; random phases then run gets and puts over small key pools
// at several capacities, most with random idling on both channels.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   localparam int ENTRIES      = MAX_ENTRIES_DEF;
   // Cycles allowed for a put to finish after the last expected result.
   localparam int QUIET_CYCLES = 2 * ENTRIES + 20;
   // Cycles without any accepted item before the run is declared hung. The
   // longest legitimate quiet spell is the long receiver hold below.
   localparam int STALL_LIMIT  = 5000;
   localparam int LONG_HOLD    = 400;

   typedef struct packed {
      logic                     found;
      logic signed [READ_W-1:0] read_value;
   } read_result_type;

   // Clock, reset and every block input start at known values.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_action = 1'b0;
   logic [KEY_W-1:0]     req_lookup_key = '0;
   logic [VALUE_W-1:0]   req_store_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_found;
   logic [READ_W-1:0]    rsp_read_value;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_W-1:0]     csr_capacity_in_use = '0;

   lru_key_value_cache_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_lookup_key      (req_lookup_key),
      .req_store_value     (req_store_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_read_value      (rsp_read_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Behavioral copy of the cache. Each slot holds a key, a value, a valid
   // mark and a recency rank, where rank 0 is the most recently used entry.
   // ------------------------------------------------------------------------
   logic [KEY_W-1:0]   slot_key   [ENTRIES];
   logic [VALUE_W-1:0] slot_value [ENTRIES];
   bit                 slot_valid [ENTRIES];
   int                 slot_rank  [ENTRIES];
   int                 slots_used = 0;
   logic [CFG_W-1:0]   capacity_setting = CAPACITY_RESET;

   // Predicted get results, oldest first.
   read_result_type pending_reads[$];

   int error_count   = 0;
   int gets_seen     = 0;
   int hits_seen     = 0;
   int puts_seen     = 0;
   int settings_used = 0;

   // Move one entry to the front: every valid entry that was more recent
   // than it ages by one step.
   function automatic void make_most_recent(input int idx);
      int old_rank;
      old_rank = slot_rank[idx];
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && slot_rank[i] < old_rank) begin
            slot_rank[i]++;
         end
      end
      slot_rank[idx] = 0;
   endfunction

   // Apply one request to the copy. Returns 1 when the request yields a
   // result item, which is then placed in res.
   function automatic bit cache_access(input action_type act, input logic [KEY_W-1:0] k,
                                       input logic [VALUE_W-1:0] v,
                                       output read_result_type res);
      int idx;
      int cap;
      int free_slot;
      idx = -1;
      free_slot = -1;
      res = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (idx < 0 && slot_valid[i] && slot_key[i] == k) begin
            idx = i;
         end
      end
      if (act == ACTION_GET) begin
         if (idx >= 0) begin
            make_most_recent(idx);
            res.found = 1'b1;
            res.read_value = {1'b0, slot_value[idx]};
         end else begin
            res.found = 1'b0;
            res.read_value = MISS_VALUE;
         end
         return 1'b1;
      end
      if (idx >= 0) begin
         slot_value[idx] = v;
         make_most_recent(idx);
         return 1'b0;
      end
      // New key. A setting of zero behaves as one, and anything above the
      // number of slots behaves as the number of slots.
      cap = capacity_setting;
      if (cap == 0) begin
         cap = 1;
      end
      if (cap > ENTRIES) begin
         cap = ENTRIES;
      end
      // When full, drop every entry at or beyond the last kept rank. After a
      // capacity cut this can drop several entries at once.
      if (slots_used >= cap) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && slot_rank[i] >= cap - 1) begin
               slot_valid[i] = 1'b0;
               slots_used--;
            end
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i]) begin
            slot_rank[i]++;
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (free_slot < 0 && !slot_valid[i]) begin
            free_slot = i;
         end
      end
      if (free_slot >= 0) begin
         slot_valid[free_slot] = 1'b1;
         slot_key[free_slot]   = k;
         slot_value[free_slot] = v;
         slot_rank[free_slot]  = 0;
         slots_used++;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor and checker. All three channels are sampled at the rising edge.
   // A result is checked before the request of the same edge is predicted,
   // so a result can never be matched against its own request's prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      read_result_type want;
      read_result_type pred;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reads.size() == 0) begin
               $error("result item with nothing expected: found %0b read_value %0d",
                      rsp_found, $signed(rsp_read_value));
               error_count++;
            end else begin
               want = pending_reads.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0b, got %0b", want.found, rsp_found);
                  error_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         $signed(want.read_value), $signed(rsp_read_value));
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            capacity_setting = csr_capacity_in_use;
         end
         if (req_valid && req_ready) begin
            if (cache_access(action_type'(req_action), req_lookup_key, req_store_value, pred)) begin
               pending_reads.push_back(pred);
               gets_seen++;
               if (pred.found) begin
                  hits_seen++;
               end
            end else begin
               puts_seen++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. Normally ready, with random stall bursts while rx_idle_on is
   // set. A test can ask for one long hold, which this process counts down on
   // its own while the sender keeps going.
   // ------------------------------------------------------------------------
   bit rx_idle_on = 1'b1;
   bit tx_idle_on = 1'b1;
   int long_hold_request = 0;
   int rx_hold_left = 0;

   always @(posedge clock) begin
      if (long_hold_request > 0) begin
         rx_hold_left = long_hold_request;
         long_hold_request = 0;
      end
      if (rx_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left--;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left = $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: any accepted item on any channel restarts the count.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
         $display("lru_key_value_cache_unit_test: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sender side. send_item returns in the time step of the acceptance edge
   // and leaves req_valid high, so a following item can go out back to back.
   // Anything that stops sending lowers req_valid in that same step.
   // ------------------------------------------------------------------------
   task automatic send_item(input action_type act, input logic [KEY_W-1:0] k,
                            input logic [VALUE_W-1:0] v);
      int gap;
      gap = 0;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_lookup_key  <= k;
      req_store_value <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every predicted result has been checked.
   // The first edge lets the monitor record an item accepted just now.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reads.size() != 0) @(posedge clock);
   endtask

   // The capacity is only changed with the block idle: all results in and
   // enough extra cycles for a trailing put to finish.
   task automatic set_capacity(input logic [CFG_W-1:0] cap);
      wait_for_results();
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_capacity_in_use <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Lookup on an empty cache, then puts and gets at the extremes of the key
   // and value ranges, an update of a present key, and a plain miss.
   task automatic test_lookup_and_update();
      send_item(ACTION_GET, 32'h0000_0000, 31'h0);
      send_item(ACTION_PUT, 32'h8000_0000, 31'h0000_0000);
      send_item(ACTION_PUT, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_item(ACTION_PUT, 32'h0000_0000, 31'h0000_3039);
      send_item(ACTION_PUT, 32'hFFFF_FFFF, 31'h0000_0037);
      send_item(ACTION_GET, 32'h8000_0000, 31'h7FFF_FFFF);
      send_item(ACTION_GET, 32'h7FFF_FFFF, 31'h0);
      send_item(ACTION_PUT, 32'hFFFF_FFFF, 31'h2AAA_AAAA);
      send_item(ACTION_GET, 32'hFFFF_FFFF, 31'h0);
      send_item(ACTION_GET, 32'h0000_0001, 31'h0);
      wait_for_results();
   endtask

   // Cut the capacity below the current occupancy. Nothing goes at once; the
   // next new key keeps only the most recent entries and then goes in.
   task automatic test_shrink_below_occupancy();
      set_capacity(5'd2);
      send_item(ACTION_GET, 32'h0000_0000, 31'h0);
      send_item(ACTION_PUT, 32'h0000_004D, 31'h5555_5555);
      send_item(ACTION_GET, 32'hFFFF_FFFF, 31'h0);
      send_item(ACTION_GET, 32'h0000_0000, 31'h0);
      send_item(ACTION_GET, 32'h0000_004D, 31'h0);
      wait_for_results();
   endtask

   // A capacity of one keeps a single entry; a setting of zero acts the same.
   task automatic test_capacity_one_and_zero();
      set_capacity(5'd1);
      send_item(ACTION_PUT, 32'h0000_0005, 31'h0000_0A05);
      send_item(ACTION_PUT, 32'h0000_0006, 31'h0000_0A06);
      send_item(ACTION_GET, 32'h0000_0005, 31'h0);
      send_item(ACTION_GET, 32'h0000_0006, 31'h0);
      set_capacity(5'd0);
      send_item(ACTION_PUT, 32'h0000_0009, 31'h0000_0A09);
      send_item(ACTION_GET, 32'h0000_0006, 31'h0);
      send_item(ACTION_GET, 32'h0000_0009, 31'h0);
      wait_for_results();
   endtask

   // Hold the receiver off for a long stretch while gets keep coming, so the
   // output register fills and the block stops taking requests. Afterwards
   // the sender pauses until every result has been drained.
   task automatic test_output_backpressure();
      logic [KEY_W-1:0] keys [4];
      set_capacity(5'd16);
      tx_idle_on = 1'b0;
      foreach (keys[i]) begin
         keys[i] = $urandom;
         send_item(ACTION_PUT, keys[i], 31'($urandom));
      end
      long_hold_request = LONG_HOLD;
      repeat (12) begin
         send_item(ACTION_GET, keys[$urandom_range(0, 3)], 31'h0);
      end
      wait_for_results();
      tx_idle_on = 1'b1;
   endtask

   // Random gets and puts. Keys mostly come from a pool a little larger than
   // the capacity, so hits, updates and evictions all occur often; the rest
   // are fresh random keys that normally miss.
   task automatic run_random_phase(input logic [CFG_W-1:0] cap, input int n_items,
                                   input bit idle);
      logic [KEY_W-1:0] key_pool[$];
      logic [KEY_W-1:0] k;
      int eff;
      action_type act;
      set_capacity(cap);
      tx_idle_on = idle;
      rx_idle_on = idle;
      eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
      repeat (eff + eff / 2 + 2) key_pool.push_back($urandom);
      repeat (n_items) begin
         act = ($urandom_range(0, 1) == 0) ? ACTION_GET : ACTION_PUT;
         if ($urandom_range(0, 99) < 85) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end else begin
            k = $urandom;
         end
         send_item(act, k, 31'($urandom));
      end
      wait_for_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_lookup_and_update();
      test_shrink_below_occupancy();
      test_capacity_one_and_zero();
      test_output_backpressure();

      // Settings above the slot count act as the slot count.
      run_random_phase(5'd31, 220, 1'b1);
      run_random_phase(5'd5, 220, 1'b1);
      run_random_phase(5'd1, 200, 1'b1);
      run_random_phase(5'd0, 200, 1'b1);
      run_random_phase(5'd3, 220, 1'b1);
      run_random_phase(5'd9, 220, 1'b1);
      run_random_phase(5'd17, 220, 1'b1);
      // The closing phase runs with no idling on either side.
      run_random_phase(5'd16, 260, 1'b0);

      wait_for_results();
      repeat (QUIET_CYCLES) @(posedge clock);

      $display("Covered %0d gets (%0d hits, %0d misses) and %0d puts",
               gets_seen, hits_seen, gets_seen - hits_seen, puts_seen);
      $display("over %0d capacity writes, with idling and a long output stall.",
               settings_used);
      if (error_count == 0) begin
         $display("lru_key_value_cache_unit_test: clean");
      end else begin
         $display("lru_key_value_cache_unit_test: errors");
      end
      $finish;
   end

endmodule
